/* rtl/assert_macros.svh */
// Assertion macros used by the RTL core.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define DSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define DSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/dsq_pkg.sv */
`timescale 1ns / 1ps

package dsq_pkg;

    // Coordinate width and fixed-point format of the tangent constants.
    localparam int COORD_WIDTH = 16;
    localparam int TAN_BITS    = 31;
    localparam int NUM_CELLS   = 4;
    localparam int COUNT_W     = $clog2(NUM_CELLS + 1);
    localparam int PROD_W      = COORD_WIDTH + TAN_BITS;
    localparam int SECTOR_W    = 5;
    localparam int FOLD_W      = 4;

    // Sector counts used when unfolding the octant into a full turn.
    localparam logic [FOLD_W-1:0]   OCTANT_SECTORS = FOLD_W'(8);
    localparam logic [SECTOR_W-1:0] HALF_TURN      = SECTOR_W'(16);

    // tan((2k+1)*pi/32) in unsigned Q0.31, one per cell.
    localparam logic [TAN_BITS-1:0] HALF_TAN_Q31 [NUM_CELLS] = '{
        TAN_BITS'(211508678),
        TAN_BITS'(651432043),
        TAN_BITS'(1147853924),
        TAN_BITS'(1762394284)
    };

    // One input beat: source and target points.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] from_x;
        logic signed [COORD_WIDTH-1:0] from_y;
        logic signed [COORD_WIDTH-1:0] to_x;
        logic signed [COORD_WIDTH-1:0] to_y;
    } points_t;

    // One result beat.
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic                coincident;
    } result_t;

    // Data handed from cell to cell along the chain.
    typedef struct packed {
        logic                   valid;
        logic [COORD_WIDTH-1:0] lo;
        logic [COORD_WIDTH-1:0] hi;
        logic                   steep;
        logic                   dx_neg;
        logic                   dy_neg;
        logic                   coincident;
        logic [COUNT_W-1:0]     count;
    } lane_t;

endpackage

/* rtl/dsq_prep.sv */
`timescale 1ns / 1ps

module dsq_prep
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  dsq_pkg::points_t points,
    output dsq_pkg::lane_t   lane
);

    localparam int W = dsq_pkg::COORD_WIDTH;

    logic signed [W:0]  dx;
    logic signed [W:0]  dy;
    logic [W:0]         dx_abs;
    logic [W:0]         dy_abs;
    logic [W-1:0]       mag_a;
    logic [W-1:0]       mag_b;
    logic               valid_reg;
    dsq_pkg::lane_t     lane_reg;
    dsq_pkg::lane_t     lane_next;

    // Exact differences, one bit wider than the coordinates.
    assign dx = {points.to_x[W-1], points.to_x} - {points.from_x[W-1], points.from_x};
    assign dy = {points.to_y[W-1], points.to_y} - {points.from_y[W-1], points.from_y};

    // Magnitudes never exceed 2^W - 1, so W bits hold them.
    assign dx_abs = dx[W] ? (W + 1)'(-dx) : dx;
    assign dy_abs = dy[W] ? (W + 1)'(-dy) : dy;
    assign mag_a  = dx_abs[W-1:0];
    assign mag_b  = dy_abs[W-1:0];

    // Fold into the first octant: lo over hi is the tangent that the cells test.
    always_comb
    begin
        lane_next            = '0;
        lane_next.steep      = (mag_b > mag_a);
        lane_next.lo         = lane_next.steep ? mag_a : mag_b;
        lane_next.hi         = lane_next.steep ? mag_b : mag_a;
        lane_next.dx_neg     = dx[W];
        lane_next.dy_neg     = dy[W];
        lane_next.coincident = (dx == '0) && (dy == '0);
        lane_next.count      = '0;
    end

    // Valid flag is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    always_comb
    begin
        lane       = lane_reg;
        lane.valid = valid_reg;
    end

endmodule

/* rtl/dsq_cell.sv */
`timescale 1ns / 1ps

module dsq_cell
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [dsq_pkg::TAN_BITS-1:0]         tan_q,
    input  dsq_pkg::lane_t                       lane_in,
    output dsq_pkg::lane_t                       lane_out
);

    localparam int PW = dsq_pkg::PROD_W;

    logic [PW-1:0]   prod;
    logic [PW-1:0]   lhs;
    logic            hit;
    logic            valid_reg;
    dsq_pkg::lane_t  lane_reg;
    dsq_pkg::lane_t  lane_next;

    // Test lo/hi against one boundary tangent; steep angles use a strict compare.
    assign prod = PW'(lane_in.hi) * PW'(tan_q);
    assign lhs  = {lane_in.lo, dsq_pkg::TAN_BITS'(0)};
    assign hit  = lane_in.steep ? (lhs > prod) : (lhs >= prod);

    always_comb
    begin
        lane_next       = lane_in;
        lane_next.count = lane_in.count + dsq_pkg::COUNT_W'(hit);
    end

    // Valid flag is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= lane_in.valid;
        end
    end

    // Payload register handed to the next cell.
    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    always_comb
    begin
        lane_out       = lane_reg;
        lane_out.valid = valid_reg;
    end

endmodule

/* rtl/direction_sector_quantizer_core.sv */
`timescale 1ns / 1ps

// Direction sector quantizer. Each beat on points gives the direction from the
// source to the target as one of 32 sectors, counterclockwise from +x, plus a
// coincident flag (sector 0) when the points are equal. A new beat is accepted
// every cycle: busy stays low. The result appears on result with done high for
// exactly one cycle, after the beat has passed six register stages: one fold
// stage loaded at the accepting edge, four boundary cells in a chain (one cell
// per boundary tangent) and one output stage. The receiver cannot stall, so
// results must be taken the cycle they appear.

`include "assert_macros.svh"

module direction_sector_quantizer_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dsq_pkg::points_t points,
    output logic             done,
    output dsq_pkg::result_t result
);

    localparam int NC = dsq_pkg::NUM_CELLS;
    localparam int SW = dsq_pkg::SECTOR_W;

    dsq_pkg::lane_t                lanes [NC+1];
    dsq_pkg::lane_t                tail;
    logic [dsq_pkg::FOLD_W-1:0]    fold;
    logic [SW-1:0]                 fold_w;
    logic [SW-1:0]                 sector_next;
    logic                          done_reg;
    dsq_pkg::result_t              result_reg;

    assign busy = 1'b0;

    // Fold the differences into the first octant.
    dsq_prep u_prep
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (start && !busy),
        .points (points),
        .lane   (lanes[0])
    );

    // One cell per boundary tangent, each adding its compare to the count.
    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        dsq_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .tan_q    (dsq_pkg::HALF_TAN_Q31[k]),
            .lane_in  (lanes[k]),
            .lane_out (lanes[k+1])
        );
    end

    assign tail = lanes[NC];

    // Octant offset, then unfold into the quadrant; 5-bit arithmetic wraps 32 to 0.
    assign fold   = tail.steep ? (dsq_pkg::OCTANT_SECTORS - dsq_pkg::FOLD_W'(tail.count))
                               : dsq_pkg::FOLD_W'(tail.count);
    assign fold_w = SW'(fold);

    always_comb
    begin
        unique case ({tail.dy_neg, tail.dx_neg})
            2'b00:   sector_next = fold_w;
            2'b01:   sector_next = dsq_pkg::HALF_TURN - fold_w;
            2'b11:   sector_next = dsq_pkg::HALF_TURN + fold_w;
            2'b10:   sector_next = SW'(0) - fold_w;
            default: sector_next = '0;
        endcase
    end

    // Output strobe is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tail.valid;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        result_reg.coincident <= tail.coincident;
        result_reg.sector     <= tail.coincident ? SW'(0) : sector_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A result beat always traces back to an accepted beat.
    `DSQ_ASSERT_IMP(a_done_has_source, clk, rst_n, done, $past(start && !busy, 6))
    // Coincident results carry sector zero.
    `DSQ_ASSERT_IMP(a_coincident_zero, clk, rst_n, done && result.coincident, result.sector == '0)
    // The coincident flag matches the points that were on the input when its beat was accepted.
    `DSQ_ASSERT_IMP(a_coincident_src, clk, rst_n, done,
                    result.coincident == $past((points.from_x == points.to_x)
                                               && (points.from_y == points.to_y), 6))

endmodule

/* verif/dsq_direction_checker.sv */
`timescale 1ns / 1ps

// Watches the point and result channels of the direction sector quantizer.
// Every accepted beat is turned into its expected sector, and every result
// beat is compared with the oldest expectation still waiting.
module dsq_direction_checker
    import dsq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  points_t points,
    input  logic    done,
    input  result_t result,
    output int      mismatch_count,
    output int      outstanding
);

    // Boundary tangents tan((2k+1)*pi/32) in unsigned Q0.31.
    localparam logic [63:0] BOUNDARY_TAN [4] = '{
        64'd211508678,
        64'd651432043,
        64'd1147853924,
        64'd1762394284
    };
    localparam int TAN_SHIFT       = 31;
    localparam int OCTANT_STEPS    = 8;
    localparam int HALF_TURN_STEPS = 16;
    localparam int FULL_TURN_STEPS = 32;

    result_t pending_directions [$];
    result_t due;
    int      errors = 0;
    int      queued = 0;

    assign mismatch_count = errors;
    assign outstanding    = queued;

    // Direction from source to target, rounded to the nearest of 32 sectors.
    function automatic result_t quantize_direction(input points_t p);
        logic signed [COORD_WIDTH:0] dx;
        logic signed [COORD_WIDTH:0] dy;
        logic [63:0]                 a;
        logic [63:0]                 b;
        int                          fold;
        int                          turn;
        result_t                     r;
        dx = $signed({p.to_x[COORD_WIDTH-1], p.to_x})
           - $signed({p.from_x[COORD_WIDTH-1], p.from_x});
        dy = $signed({p.to_y[COORD_WIDTH-1], p.to_y})
           - $signed({p.from_y[COORD_WIDTH-1], p.from_y});
        r.sector     = '0;
        r.coincident = 1'b1;
        if (dx == 0 && dy == 0)
        begin
            return r;
        end
        a = (dx < 0) ? 64'(-dx) : 64'(dx);
        b = (dy < 0) ? 64'(-dy) : 64'(dy);
        // Fold into the first octant and count the boundaries passed.
        fold = 0;
        if (b <= a)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if ((b << TAN_SHIFT) >= a * BOUNDARY_TAN[k])
                begin
                    fold++;
                end
            end
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                if ((a << TAN_SHIFT) > b * BOUNDARY_TAN[k])
                begin
                    fold++;
                end
            end
            fold = OCTANT_STEPS - fold;
        end
        // Unfold into the quadrant given by the signs of the differences.
        if (dy >= 0)
        begin
            turn = (dx >= 0) ? fold : HALF_TURN_STEPS - fold;
        end
        else
        begin
            turn = (dx < 0) ? HALF_TURN_STEPS + fold : FULL_TURN_STEPS - fold;
        end
        r.sector     = turn[SECTOR_W-1:0];
        r.coincident = 1'b0;
        return r;
    endfunction

    // Record accepted beats first, then check the result beat of this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pending_directions.push_back(quantize_direction(points));
            end
            if (done)
            begin
                if (pending_directions.size() == 0)
                begin
                    $error("result beat with no expectation waiting: sector %0d coincident %0d",
                           result.sector, result.coincident);
                    errors++;
                end
                else
                begin
                    due = pending_directions.pop_front();
                    if (result.sector !== due.sector)
                    begin
                        $error("sector: expected %0d, actual %0d", due.sector, result.sector);
                        errors++;
                    end
                    if (result.coincident !== due.coincident)
                    begin
                        $error("coincident: expected %0d, actual %0d",
                               due.coincident, result.coincident);
                        errors++;
                    end
                end
            end
        end
        queued <= pending_directions.size();
    end

endmodule

/* verif/direction_sector_quantizer_core_tb.sv */
`timescale 1ns / 1ps

// Drives point pairs into the direction sector quantizer and gives the verdict.
module direction_sector_quantizer_core_tb;

    import dsq_pkg::*;

    localparam int COORD_MIN     = -(1 << (COORD_WIDTH - 1));
    localparam int COORD_MAX     = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int RESET_CYCLES  = 11;
    localparam int PHASE_ITEMS   = 350;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PCT [4]  = '{0, 65, 22, 65};

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    points_t points = '0;
    logic    busy;
    logic    done;
    result_t result;
    int      mismatch_count;
    int      outstanding;
    int      idle_pct = 0;

    direction_sector_quantizer_core i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .points (points),
        .done   (done),
        .result (result)
    );

    dsq_direction_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .points         (points),
        .done           (done),
        .result         (result),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // One beat at absolute coordinates, followed by a random idle gap with probability idle_pct percent.
    task automatic send_at(input int fx, input int fy, input int tx, input int ty);
        points_t p;
        p.from_x = COORD_WIDTH'(fx);
        p.from_y = COORD_WIDTH'(fy);
        p.to_x   = COORD_WIDTH'(tx);
        p.to_y   = COORD_WIDTH'(ty);
        start  <= 1'b1;
        points <= p;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 12 : 3))
            begin
                @(posedge clk);
            end
        end
    endtask

    // Source point chosen at random so that source plus offset stays in range.
    function automatic int pick_origin(input int d);
        int lo;
        int hi;
        lo = COORD_MIN - ((d < 0) ? d : 0);
        hi = COORD_MAX - ((d > 0) ? d : 0);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // One beat given by its offset from a random source point.
    task automatic send_offset(input int dx, input int dy);
        int fx;
        int fy;
        fx = pick_origin(dx);
        fy = pick_origin(dy);
        send_at(fx, fy, fx + dx, fy + dy);
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One random beat of one of several kinds; only some offsets land on or near a sector boundary.
    task automatic random_item();
        int kind;
        int a;
        int b;
        int swap;
        int jitter;
        int k;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            send_at($urandom, $urandom, $urandom, $urandom);
        end
        else if (kind < 55)
        begin
            a      = $urandom_range(1, 30000);
            k      = $urandom_range(0, 3);
            jitter = $urandom_range(0, 2);
            b      = int'((longint'(a) * longint'(HALF_TAN_Q31[k])) >>> TAN_BITS) + jitter - 1;
            if (b < 0)
            begin
                b = 0;
            end
            if ($urandom_range(0, 1))
            begin
                swap = a;
                a    = b;
                b    = swap;
            end
            send_offset($urandom_range(0, 1) ? -a : a, $urandom_range(0, 1) ? -b : b);
        end
        else if (kind < 75)
        begin
            send_offset(int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8);
        end
        else if (kind < 85)
        begin
            // Axis-aligned and diagonal offsets.
            a = $urandom_range(1, COORD_MAX);
            b = $urandom_range(0, 1) ? -a : a;
            case ($urandom_range(0, 2))
                0:       send_offset(b, 0);
                1:       send_offset(0, b);
                default: send_offset(b, $urandom_range(0, 1) ? -a : a);
            endcase
        end
        else if (kind < 90)
        begin
            send_offset(0, 0);
        end
        else
        begin
            send_offset(int'($urandom_range(0, 4000)) - 2000,
                        int'($urandom_range(0, 4000)) - 2000);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (RESET_CYCLES)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: coincidence, the axes, the diagonals, the largest spans, the wrap.
        send_at(0, 0, 0, 0);
        send_at(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        send_at(-1, -1, -1, -1);
        send_offset(5, 0);
        send_offset(-5, 0);
        send_offset(0, 5);
        send_offset(0, -5);
        send_at(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_at(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_at(COORD_MAX, 0, COORD_MIN, 0);
        send_at(COORD_MIN, 0, COORD_MAX, 0);
        send_at(0, COORD_MIN, 0, COORD_MAX);
        send_at(0, COORD_MAX, 0, COORD_MIN);
        send_at(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_offset(1, 1);
        send_offset(-1, 1);
        send_offset(-1, -1);
        send_offset(1, -1);
        send_offset(1000, -1);
        send_offset(1000, -100);
        send_offset(-1000, -100);
        send_offset(-1000, 100);
        send_offset(1, 1000);
        send_offset(100, 1000);
        drain();

        // Four random phases with idle rates of 0, 65, 22 and 65 percent, each drained at its end.
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = IDLE_PCT[phase];
            repeat (PHASE_ITEMS)
            begin
                random_item();
            end
            drain();
        end

        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* direction_sector_quantizer_core.f */
+incdir+rtl
rtl/dsq_pkg.sv
rtl/dsq_prep.sv
rtl/dsq_cell.sv
rtl/direction_sector_quantizer_core.sv
verif/dsq_direction_checker.sv
verif/direction_sector_quantizer_core_tb.sv
